// ===== sv/i2cram_pkg.sv =====
// ----------------------------------------------------------------------------
// i2cram_pkg
// shared types and constants for the i2c register access master
// ----------------------------------------------------------------------------
package i2cram_pkg;

    localparam logic [7:0] ACK_WAIT_RESET = 8'd250;

    typedef enum logic [1:0] {
        ACT_TICK  = 2'd0,
        ACT_WRITE = 2'd1,
        ACT_READ  = 2'd2
    } action_t;

    typedef enum logic [4:0] {
        PH_IDLE         = 5'd0,
        PH_S_SETUP      = 5'd1,
        PH_S_FALL       = 5'd2,
        PH_S_HOLD       = 5'd3,
        PH_B0_DATA_LOW  = 5'd4,
        PH_B0_DATA_HIGH = 5'd5,
        PH_B0_ACK_LOW   = 5'd6,
        PH_B0_ACK_HIGH  = 5'd7,
        PH_B1_DATA_LOW  = 5'd8,
        PH_B1_DATA_HIGH = 5'd9,
        PH_B1_ACK_LOW   = 5'd10,
        PH_B1_ACK_HIGH  = 5'd11,
        PH_B2_DATA_LOW  = 5'd12,
        PH_B2_DATA_HIGH = 5'd13,
        PH_B2_ACK_LOW   = 5'd14,
        PH_B2_ACK_HIGH  = 5'd15,
        PH_B3_DATA_LOW  = 5'd16,
        PH_B3_DATA_HIGH = 5'd17,
        PH_B3_ACK_LOW   = 5'd18,
        PH_B3_ACK_HIGH  = 5'd19,
        PH_RS_PREP      = 5'd20,
        PH_RS_SETUP     = 5'd21,
        PH_RS_FALL      = 5'd22,
        PH_RS_HOLD      = 5'd23,
        PH_RD_LOW       = 5'd24,
        PH_RD_HIGH      = 5'd25,
        PH_NK_LOW       = 5'd26,
        PH_NK_HIGH      = 5'd27,
        PH_P_LOW        = 5'd28,
        PH_P_HIGH       = 5'd29,
        PH_P_DONE       = 5'd30
    } phase_t;

    // sub-step inside a byte slot, taken from the low phase bits
    localparam logic [1:0] SUB_DATA_LOW  = 2'd0;
    localparam logic [1:0] SUB_DATA_HIGH = 2'd1;
    localparam logic [1:0] SUB_ACK_LOW   = 2'd2;
    localparam logic [1:0] SUB_ACK_HIGH  = 2'd3;

    // byte slots: address+w, register, write data, address+r
    localparam logic [2:0] SLOT_ADDR_W = 3'd0;
    localparam logic [2:0] SLOT_REG    = 3'd1;
    localparam logic [2:0] SLOT_DATA   = 3'd2;

    typedef struct packed {
        logic [1:0] action;
        logic [6:0] target_addr;
        logic [7:0] target_reg;
        logic [7:0] write_data;
        logic       sda_in;
    } in_t;

    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       sda_drive;
        logic       busy_res;
        logic       done_res;
        logic       nack_error;
        logic [7:0] read_data;
    } out_t;

endpackage

// ===== sv/i2c_register_access_master.sv =====
// ----------------------------------------------------------------------------
// i2c_register_access_master
// Each input beat is one bus phase tick carrying the sampled SDA level; each
// accepted beat gives exactly one result beat with the SCL/SDA levels for that
// tick plus busy, done, nack_error and the last read byte. Action 1 starts a
// register write, action 2 a register read, both only from idle. The block
// takes one beat per clock cycle: the phase sequencer updates in a single
// pass and the result sits in one output register, so in_ready drops only
// while that register is full and out_ready is low. A missing acknowledge
// (more than ack_wait_limit high samples in an ack slot) ends the transfer
// with one stop and nack_error on the done beat.
// ----------------------------------------------------------------------------
module i2c_register_access_master (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  i2cram_pkg::in_t   in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output i2cram_pkg::out_t  out_data,
    input  logic              cfg_we,
    input  logic [7:0]        cfg_wdata
);

    i2cram_pkg::phase_t phase_reg, phase_next, eff_phase;
    logic [2:0] bit_count_reg, bit_count_next;
    logic [7:0] shift_byte_reg, shift_byte_next;
    logic [7:0] ack_wait_count_reg, ack_wait_count_next;
    logic [6:0] held_device_reg, held_device_next;
    logic [7:0] held_register_reg, held_register_next;
    logic [7:0] held_data_reg, held_data_next;
    logic       is_read_reg, is_read_next;
    logic [7:0] received_byte_reg, received_byte_next;
    logic       failed_reg, failed_next;
    logic [7:0] ack_limit_reg;

    logic             out_valid_reg;
    i2cram_pkg::out_t out_data_reg, result;

    logic       in_fire;
    logic       start_req;
    logic       in_slot;
    logic [2:0] slot;
    logic [1:0] sub;

    assign in_ready  = !out_valid_reg || out_ready;
    assign in_fire   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign start_req = (phase_reg == i2cram_pkg::PH_IDLE) &&
                       ((in_data.action == i2cram_pkg::ACT_WRITE) ||
                        (in_data.action == i2cram_pkg::ACT_READ));
    assign eff_phase = start_req ? i2cram_pkg::PH_S_SETUP : phase_reg;

    assign in_slot = (eff_phase >= i2cram_pkg::PH_B0_DATA_LOW) &&
                     (eff_phase <= i2cram_pkg::PH_B3_ACK_HIGH);
    assign slot    = 3'(eff_phase[4:2] - 3'd1);
    assign sub     = eff_phase[1:0];

    // next state
    always_comb
    begin
        phase_next          = eff_phase;
        bit_count_next      = start_req ? 3'd0 : bit_count_reg;
        shift_byte_next     = shift_byte_reg;
        ack_wait_count_next = start_req ? 8'd0 : ack_wait_count_reg;
        held_device_next    = start_req ? in_data.target_addr : held_device_reg;
        held_register_next  = start_req ? in_data.target_reg : held_register_reg;
        held_data_next      = start_req ? in_data.write_data : held_data_reg;
        is_read_next        = start_req ? (in_data.action == i2cram_pkg::ACT_READ)
                                        : is_read_reg;
        failed_next         = start_req ? 1'b0 : failed_reg;
        received_byte_next  = received_byte_reg;

        if (in_slot)
        begin
            case (sub)
                i2cram_pkg::SUB_DATA_LOW:
                begin
                    phase_next = i2cram_pkg::phase_t'(5'(eff_phase + 5'd1));
                end
                i2cram_pkg::SUB_DATA_HIGH:
                begin
                    shift_byte_next = {shift_byte_reg[6:0], 1'b0};
                    if (bit_count_reg == 3'd7)
                        phase_next = i2cram_pkg::phase_t'(5'(eff_phase + 5'd1));
                    else
                        phase_next = i2cram_pkg::phase_t'(5'(eff_phase - 5'd1));
                    bit_count_next = 3'(bit_count_reg + 3'd1);
                end
                i2cram_pkg::SUB_ACK_LOW:
                begin
                    ack_wait_count_next = 8'd0;
                    phase_next = i2cram_pkg::phase_t'(5'(eff_phase + 5'd1));
                end
                default:
                begin
                    if (!in_data.sda_in)
                    begin
                        case (slot)
                            i2cram_pkg::SLOT_ADDR_W:
                            begin
                                phase_next      = i2cram_pkg::PH_B1_DATA_LOW;
                                shift_byte_next = held_register_reg;
                                bit_count_next  = 3'd0;
                            end
                            i2cram_pkg::SLOT_REG:
                            begin
                                if (is_read_reg)
                                    phase_next = i2cram_pkg::PH_RS_PREP;
                                else
                                begin
                                    phase_next      = i2cram_pkg::PH_B2_DATA_LOW;
                                    shift_byte_next = held_data_reg;
                                    bit_count_next  = 3'd0;
                                end
                            end
                            i2cram_pkg::SLOT_DATA:
                            begin
                                phase_next = i2cram_pkg::PH_P_LOW;
                            end
                            default:
                            begin
                                phase_next      = i2cram_pkg::PH_RD_LOW;
                                bit_count_next  = 3'd0;
                                shift_byte_next = 8'd0;
                            end
                        endcase
                    end
                    else if (ack_wait_count_reg >= ack_limit_reg)
                    begin
                        failed_next = 1'b1;
                        phase_next  = i2cram_pkg::PH_P_LOW;
                    end
                    else
                    begin
                        ack_wait_count_next = 8'(ack_wait_count_reg + 8'd1);
                    end
                end
            endcase
        end
        else
        begin
            case (eff_phase)
                i2cram_pkg::PH_S_SETUP:  phase_next = i2cram_pkg::PH_S_FALL;
                i2cram_pkg::PH_S_FALL:   phase_next = i2cram_pkg::PH_S_HOLD;
                i2cram_pkg::PH_S_HOLD:
                begin
                    phase_next      = i2cram_pkg::PH_B0_DATA_LOW;
                    shift_byte_next = {held_device_reg, 1'b0};
                    bit_count_next  = 3'd0;
                end
                i2cram_pkg::PH_RS_PREP:  phase_next = i2cram_pkg::PH_RS_SETUP;
                i2cram_pkg::PH_RS_SETUP: phase_next = i2cram_pkg::PH_RS_FALL;
                i2cram_pkg::PH_RS_FALL:  phase_next = i2cram_pkg::PH_RS_HOLD;
                i2cram_pkg::PH_RS_HOLD:
                begin
                    phase_next      = i2cram_pkg::PH_B3_DATA_LOW;
                    shift_byte_next = {held_device_reg, 1'b1};
                    bit_count_next  = 3'd0;
                end
                i2cram_pkg::PH_RD_LOW:   phase_next = i2cram_pkg::PH_RD_HIGH;
                i2cram_pkg::PH_RD_HIGH:
                begin
                    shift_byte_next = {shift_byte_reg[6:0], in_data.sda_in};
                    if (bit_count_reg == 3'd7)
                    begin
                        received_byte_next = {shift_byte_reg[6:0], in_data.sda_in};
                        phase_next         = i2cram_pkg::PH_NK_LOW;
                    end
                    else
                        phase_next = i2cram_pkg::PH_RD_LOW;
                    bit_count_next = 3'(bit_count_reg + 3'd1);
                end
                i2cram_pkg::PH_NK_LOW:   phase_next = i2cram_pkg::PH_NK_HIGH;
                i2cram_pkg::PH_NK_HIGH:  phase_next = i2cram_pkg::PH_P_LOW;
                i2cram_pkg::PH_P_LOW:    phase_next = i2cram_pkg::PH_P_HIGH;
                i2cram_pkg::PH_P_HIGH:   phase_next = i2cram_pkg::PH_P_DONE;
                default:                 phase_next = i2cram_pkg::PH_IDLE;
            endcase
        end
    end

    // pin levels and status for this tick
    always_comb
    begin
        result            = '0;
        result.busy_res   = 1'b1;
        result.read_data  = received_byte_next;
        if (in_slot)
        begin
            case (sub)
                i2cram_pkg::SUB_DATA_LOW:
                begin
                    result.scl_out   = 1'b0;
                    result.sda_out   = shift_byte_reg[7];
                    result.sda_drive = 1'b1;
                end
                i2cram_pkg::SUB_DATA_HIGH:
                begin
                    result.scl_out   = 1'b1;
                    result.sda_out   = shift_byte_reg[7];
                    result.sda_drive = 1'b1;
                end
                i2cram_pkg::SUB_ACK_LOW:
                begin
                    result.scl_out   = 1'b0;
                    result.sda_out   = 1'b1;
                    result.sda_drive = 1'b0;
                end
                default:
                begin
                    result.scl_out   = 1'b1;
                    result.sda_out   = 1'b1;
                    result.sda_drive = 1'b0;
                end
            endcase
        end
        else
        begin
            case (eff_phase)
                i2cram_pkg::PH_S_SETUP, i2cram_pkg::PH_RS_SETUP, i2cram_pkg::PH_NK_HIGH:
                begin
                    result.scl_out   = 1'b1;
                    result.sda_out   = 1'b1;
                    result.sda_drive = 1'b1;
                end
                i2cram_pkg::PH_S_FALL, i2cram_pkg::PH_RS_FALL, i2cram_pkg::PH_P_HIGH:
                begin
                    result.scl_out   = 1'b1;
                    result.sda_out   = 1'b0;
                    result.sda_drive = 1'b1;
                end
                i2cram_pkg::PH_S_HOLD, i2cram_pkg::PH_RS_HOLD, i2cram_pkg::PH_P_LOW:
                begin
                    result.scl_out   = 1'b0;
                    result.sda_out   = 1'b0;
                    result.sda_drive = 1'b1;
                end
                i2cram_pkg::PH_RS_PREP, i2cram_pkg::PH_NK_LOW:
                begin
                    result.scl_out   = 1'b0;
                    result.sda_out   = 1'b1;
                    result.sda_drive = 1'b1;
                end
                i2cram_pkg::PH_RD_LOW:
                begin
                    result.scl_out   = 1'b0;
                    result.sda_out   = 1'b1;
                    result.sda_drive = 1'b0;
                end
                i2cram_pkg::PH_RD_HIGH:
                begin
                    result.scl_out   = 1'b1;
                    result.sda_out   = 1'b1;
                    result.sda_drive = 1'b0;
                end
                i2cram_pkg::PH_P_DONE:
                begin
                    result.scl_out    = 1'b1;
                    result.sda_out    = 1'b1;
                    result.sda_drive  = 1'b1;
                    result.done_res   = 1'b1;
                    result.nack_error = failed_reg;
                    result.busy_res   = 1'b0;
                end
                default:
                begin
                    // idle and unused codes: bus released
                    result.scl_out   = 1'b1;
                    result.sda_out   = 1'b1;
                    result.sda_drive = 1'b0;
                    result.busy_res  = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= i2cram_pkg::PH_IDLE;
            bit_count_reg      <= 3'd0;
            shift_byte_reg     <= 8'd0;
            ack_wait_count_reg <= 8'd0;
            held_device_reg    <= 7'd0;
            held_register_reg  <= 8'd0;
            held_data_reg      <= 8'd0;
            is_read_reg        <= 1'b0;
            received_byte_reg  <= 8'd0;
            failed_reg         <= 1'b0;
            ack_limit_reg      <= i2cram_pkg::ACK_WAIT_RESET;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                ack_limit_reg <= cfg_wdata;
            if (in_fire)
            begin
                phase_reg          <= phase_next;
                bit_count_reg      <= bit_count_next;
                shift_byte_reg     <= shift_byte_next;
                ack_wait_count_reg <= ack_wait_count_next;
                held_device_reg    <= held_device_next;
                held_register_reg  <= held_register_next;
                held_data_reg      <= held_data_next;
                is_read_reg        <= is_read_next;
                received_byte_reg  <= received_byte_next;
                failed_reg         <= failed_next;
            end
            if (in_fire)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_fire)
            out_data_reg <= result;
    end

endmodule

// ===== dv/i2cram_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cram_checker
// Watches the input and result channels of the i2c register access master.
// Every accepted input beat runs through a cycle model of the pin sequencer.
// The model's results are queued and compared field by field, in order, with
// the accepted result beats.
// ----------------------------------------------------------------------------
module i2cram_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_ready,
    input  i2cram_pkg::in_t   in_data,
    input  logic              out_valid,
    input  logic              out_ready,
    input  i2cram_pkg::out_t  out_data,
    input  logic              cfg_we,
    input  logic [7:0]        cfg_wdata,
    output int                error_cnt,
    output int                pending_cnt
);

    // model copy of the sequencer state
    i2cram_pkg::phase_t ph;
    logic [2:0]  bit_idx;
    logic [7:0]  shifter;
    logic [7:0]  ack_waits;
    logic [6:0]  dev_held;
    logic [7:0]  reg_held;
    logic [7:0]  data_held;
    logic        read_op;
    logic [7:0]  rx_byte;
    logic        nacked;
    logic [7:0]  ack_limit;

    i2cram_pkg::out_t bus_forecast_q[$];

    // advances the model by one tick and returns the pins and flags for it
    function automatic i2cram_pkg::out_t bus_tick(input i2cram_pkg::in_t beat);
        i2cram_pkg::out_t res;
        logic        line;
        logic [4:0]  offs;
        logic [2:0]  slot;
        logic [1:0]  sub;
        res = '0;
        res.busy_res = 1'b1;
        if (ph == i2cram_pkg::PH_IDLE && (beat.action == i2cram_pkg::ACT_WRITE ||
                                          beat.action == i2cram_pkg::ACT_READ))
        begin
            dev_held  = beat.target_addr;
            reg_held  = beat.target_reg;
            data_held = beat.write_data;
            read_op   = (beat.action == i2cram_pkg::ACT_READ);
            nacked    = 1'b0;
            ack_waits = '0;
            bit_idx   = '0;
            ph        = i2cram_pkg::PH_S_SETUP;
        end
        if (ph >= i2cram_pkg::PH_B0_DATA_LOW && ph < i2cram_pkg::PH_RS_PREP)
        begin
            offs = ph - i2cram_pkg::PH_B0_DATA_LOW;
            slot = offs[4:2];
            sub  = offs[1:0];
            line = shifter[7];
            case (sub)
                i2cram_pkg::SUB_DATA_LOW:
                begin
                    {res.scl_out, res.sda_out, res.sda_drive} = {1'b0, line, 1'b1};
                    ph = i2cram_pkg::phase_t'(ph + 5'd1);
                end
                i2cram_pkg::SUB_DATA_HIGH:
                begin
                    {res.scl_out, res.sda_out, res.sda_drive} = {1'b1, line, 1'b1};
                    shifter = {shifter[6:0], 1'b0};
                    ph = (bit_idx == 3'd7) ? i2cram_pkg::phase_t'(ph + 5'd1)
                                           : i2cram_pkg::phase_t'(ph - 5'd1);
                    bit_idx = bit_idx + 3'd1;
                end
                i2cram_pkg::SUB_ACK_LOW:
                begin
                    {res.scl_out, res.sda_out, res.sda_drive} = 3'b010;
                    ack_waits = '0;
                    ph = i2cram_pkg::phase_t'(ph + 5'd1);
                end
                default:
                begin
                    {res.scl_out, res.sda_out, res.sda_drive} = 3'b110;
                    if (!beat.sda_in)
                    begin
                        bit_idx = '0;
                        if (slot == i2cram_pkg::SLOT_ADDR_W)
                        begin
                            ph = i2cram_pkg::PH_B1_DATA_LOW;
                            shifter = reg_held;
                        end
                        else if (slot == i2cram_pkg::SLOT_REG)
                        begin
                            if (read_op)
                                ph = i2cram_pkg::PH_RS_PREP;
                            else
                            begin
                                ph = i2cram_pkg::PH_B2_DATA_LOW;
                                shifter = data_held;
                            end
                        end
                        else if (slot == i2cram_pkg::SLOT_DATA)
                            ph = i2cram_pkg::PH_P_LOW;
                        else
                        begin
                            ph = i2cram_pkg::PH_RD_LOW;
                            shifter = '0;
                        end
                    end
                    else if (ack_waits >= ack_limit)
                    begin
                        nacked = 1'b1;
                        ph = i2cram_pkg::PH_P_LOW;
                    end
                    else
                        ack_waits = ack_waits + 8'd1;
                end
            endcase
        end
        else
        begin
            case (ph)
                i2cram_pkg::PH_S_SETUP:
                begin
                    {res.scl_out, res.sda_out, res.sda_drive} = 3'b111;
                    ph = i2cram_pkg::PH_S_FALL;
                end
                i2cram_pkg::PH_S_FALL:
                begin
                    {res.scl_out, res.sda_out, res.sda_drive} = 3'b101;
                    ph = i2cram_pkg::PH_S_HOLD;
                end
                i2cram_pkg::PH_S_HOLD:
                begin
                    {res.scl_out, res.sda_out, res.sda_drive} = 3'b001;
                    ph = i2cram_pkg::PH_B0_DATA_LOW;
                    shifter = {dev_held, 1'b0};
                    bit_idx = '0;
                end
                i2cram_pkg::PH_RS_PREP:
                begin
                    {res.scl_out, res.sda_out, res.sda_drive} = 3'b011;
                    ph = i2cram_pkg::PH_RS_SETUP;
                end
                i2cram_pkg::PH_RS_SETUP:
                begin
                    {res.scl_out, res.sda_out, res.sda_drive} = 3'b111;
                    ph = i2cram_pkg::PH_RS_FALL;
                end
                i2cram_pkg::PH_RS_FALL:
                begin
                    {res.scl_out, res.sda_out, res.sda_drive} = 3'b101;
                    ph = i2cram_pkg::PH_RS_HOLD;
                end
                i2cram_pkg::PH_RS_HOLD:
                begin
                    {res.scl_out, res.sda_out, res.sda_drive} = 3'b001;
                    ph = i2cram_pkg::PH_B3_DATA_LOW;
                    shifter = {dev_held, 1'b1};
                    bit_idx = '0;
                end
                i2cram_pkg::PH_RD_LOW:
                begin
                    {res.scl_out, res.sda_out, res.sda_drive} = 3'b010;
                    ph = i2cram_pkg::PH_RD_HIGH;
                end
                i2cram_pkg::PH_RD_HIGH:
                begin
                    {res.scl_out, res.sda_out, res.sda_drive} = 3'b110;
                    shifter = {shifter[6:0], beat.sda_in};
                    if (bit_idx == 3'd7)
                    begin
                        rx_byte = shifter;
                        ph = i2cram_pkg::PH_NK_LOW;
                    end
                    else
                        ph = i2cram_pkg::PH_RD_LOW;
                    bit_idx = bit_idx + 3'd1;
                end
                i2cram_pkg::PH_NK_LOW:
                begin
                    {res.scl_out, res.sda_out, res.sda_drive} = 3'b011;
                    ph = i2cram_pkg::PH_NK_HIGH;
                end
                i2cram_pkg::PH_NK_HIGH:
                begin
                    {res.scl_out, res.sda_out, res.sda_drive} = 3'b111;
                    ph = i2cram_pkg::PH_P_LOW;
                end
                i2cram_pkg::PH_P_LOW:
                begin
                    {res.scl_out, res.sda_out, res.sda_drive} = 3'b001;
                    ph = i2cram_pkg::PH_P_HIGH;
                end
                i2cram_pkg::PH_P_HIGH:
                begin
                    {res.scl_out, res.sda_out, res.sda_drive} = 3'b101;
                    ph = i2cram_pkg::PH_P_DONE;
                end
                i2cram_pkg::PH_P_DONE:
                begin
                    {res.scl_out, res.sda_out, res.sda_drive} = 3'b111;
                    res.done_res   = 1'b1;
                    res.nack_error = nacked;
                    res.busy_res   = 1'b0;
                    ph = i2cram_pkg::PH_IDLE;
                end
                default:
                begin
                    // idle, and any phase code the sequencer never uses
                    {res.scl_out, res.sda_out, res.sda_drive} = 3'b110;
                    res.busy_res = 1'b0;
                    ph = i2cram_pkg::PH_IDLE;
                end
            endcase
        end
        res.read_data = rx_byte;
        return res;
    endfunction

    task automatic cmp_field(input string fname, input int unsigned want,
                             input int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected 'h%0h, actual 'h%0h", $time, fname,
                     want, got);
            error_cnt++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        i2cram_pkg::out_t want;
        if (!rst_n)
        begin
            ph          = i2cram_pkg::PH_IDLE;
            bit_idx     = '0;
            shifter     = '0;
            ack_waits   = '0;
            dev_held    = '0;
            reg_held    = '0;
            data_held   = '0;
            read_op     = 1'b0;
            rx_byte     = '0;
            nacked      = 1'b0;
            ack_limit   = i2cram_pkg::ACK_WAIT_RESET;
            bus_forecast_q.delete();
            error_cnt   = 0;
            pending_cnt <= 0;
        end
        else
        begin
            if (cfg_we)
                ack_limit = cfg_wdata;
            if (in_valid && in_ready)
                bus_forecast_q.push_back(bus_tick(in_data));
            if (out_valid && out_ready)
            begin
                if (bus_forecast_q.size() == 0)
                begin
                    $display("%0t: result beat with nothing expected, expected none, actual %h",
                             $time, out_data);
                    error_cnt++;
                end
                else
                begin
                    want = bus_forecast_q.pop_front();
                    cmp_field("scl_out", want.scl_out, out_data.scl_out);
                    cmp_field("sda_out", want.sda_out, out_data.sda_out);
                    cmp_field("sda_drive", want.sda_drive, out_data.sda_drive);
                    cmp_field("busy_res", want.busy_res, out_data.busy_res);
                    cmp_field("done_res", want.done_res, out_data.done_res);
                    cmp_field("nack_error", want.nack_error, out_data.nack_error);
                    cmp_field("read_data", want.read_data, out_data.read_data);
                end
            end
            pending_cnt <= bus_forecast_q.size();
        end
    end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives register write and read transfers into the i2c register access
// master with random target responses, random sender gaps and receiver
// stalls, over several acknowledge wait limits; the checker beside the block
// predicts every result beat and counts mismatches.
// ----------------------------------------------------------------------------
module testbench;

    localparam logic [1:0] ACT_UNUSED  = 2'd3;
    localparam int         CYCLE_LIMIT = 200000;
    localparam int         STAGE_BEATS = 80;
    localparam int         NUM_STAGES  = 6;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             in_valid  = 1'b0;
    logic             in_ready;
    i2cram_pkg::in_t  in_data   = '0;
    logic             out_valid;
    logic             out_ready = 1'b0;
    i2cram_pkg::out_t out_data;
    logic             cfg_we    = 1'b0;
    logic [7:0]       cfg_wdata = '0;

    int          error_cnt;
    int          pending_cnt;
    int          burst_left   = 0;
    int          beats_sent   = 0;
    int          done_seen    = 0;
    int          cycle_cnt    = 0;
    int          stretch_left = 0;
    logic        steady_ready = 1'b1;
    logic [7:0]  ready_pattern = 8'hff;
    logic [7:0]  limit_plan [NUM_STAGES];

    i2c_register_access_master u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    i2cram_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .error_cnt   (error_cnt),
        .pending_cnt (pending_cnt)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("testbench failed");
            $finish;
        end
    end

    // receiver: stretches of steady ready and stretches following a random pattern
    always @(posedge clk)
    begin
        if (stretch_left == 0)
        begin
            stretch_left  <= $urandom_range(8, 48);
            steady_ready  <= ($urandom_range(0, 2) == 0);
            ready_pattern <= 8'($urandom) | 8'h01;
        end
        else
            stretch_left <= stretch_left - 1;
        out_ready <= steady_ready ? 1'b1 : ready_pattern[stretch_left[2:0]];
    end

    // transfer completions pace the stimulus
    always @(posedge clk)
    begin
        if (out_valid && out_ready && out_data.done_res)
            done_seen <= done_seen + 1;
    end

    function automatic i2cram_pkg::in_t pack_beat(input logic [1:0] code,
                                                  input logic [6:0] dev,
                                                  input logic [7:0] regnum,
                                                  input logic [7:0] wdata,
                                                  input logic sda);
        i2cram_pkg::in_t b;
        b.action      = code;
        b.target_addr = dev;
        b.target_reg  = regnum;
        b.write_data  = wdata;
        b.sda_in      = sda;
        return b;
    endfunction

    // sda_odds: chance in eighths that the target leaves sda high on a tick
    function automatic i2cram_pkg::in_t rand_beat(input logic [1:0] code,
                                                  input int unsigned sda_odds);
        return pack_beat(code, 7'($urandom), 8'($urandom), 8'($urandom),
                         ($urandom_range(0, 7) < sda_odds));
    endfunction

    task automatic send_beat(input i2cram_pkg::in_t beat);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 7) == 0) ? 100 : $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        in_data  <= beat;
        do @(posedge clk); while (!in_ready);
        beats_sent++;
    endtask

    // stop sending and wait for every outstanding result beat
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_cnt != 0)
            @(posedge clk);
    endtask

    task automatic write_limit(input logic [7:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    // one register transfer with random content, run until its done beat is seen
    task automatic run_transfer();
        int unsigned sda_odds;
        int          mark;
        int          ticks;
        logic [1:0]  code;
        sda_odds = ($urandom_range(0, 3) == 0) ? 7 : (1 << $urandom_range(0, 2));
        repeat ($urandom_range(0, 3))
            send_beat(rand_beat($urandom_range(0, 1) ? i2cram_pkg::ACT_TICK : ACT_UNUSED,
                                4));
        mark = done_seen;
        send_beat(rand_beat($urandom_range(0, 1) ? i2cram_pkg::ACT_WRITE
                                                 : i2cram_pkg::ACT_READ, sda_odds));
        ticks = 0;
        while (done_seen == mark)
        begin
            ticks++;
            // requests only early on, while the transfer is surely still running
            if (ticks < 20 && $urandom_range(0, 5) == 0)
                code = $urandom_range(0, 1) ? i2cram_pkg::ACT_WRITE : i2cram_pkg::ACT_READ;
            else if ($urandom_range(0, 15) == 0)
                code = ACT_UNUSED;
            else
                code = i2cram_pkg::ACT_TICK;
            send_beat(rand_beat(code, sda_odds));
        end
    endtask

    initial
    begin
        int k;
        int stage_base;
        limit_plan = '{i2cram_pkg::ACK_WAIT_RESET, 8'd255, 8'd0, 8'd1,
                       8'($urandom_range(2, 254)), 8'($urandom_range(0, 15))};
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: idle ticks, then a write refused on its first ack with limit 0,
        // with requests while busy and on the done tick
        write_limit(8'd0);
        send_beat(pack_beat(ACT_UNUSED, 7'h7f, 8'hff, 8'hff, 1'b1));
        send_beat(pack_beat(i2cram_pkg::ACT_TICK, 7'h00, 8'h00, 8'h00, 1'b0));
        send_beat(pack_beat(i2cram_pkg::ACT_WRITE, 7'h7f, 8'h00, 8'hff, 1'b1));
        for (k = 2; k <= 24; k++)
        begin
            if (k == 12)
                send_beat(pack_beat(i2cram_pkg::ACT_READ, 7'h00, 8'hff, 8'h00, 1'b1));
            else if (k == 24)
                send_beat(pack_beat(i2cram_pkg::ACT_READ, 7'h00, 8'h00, 8'h00, 1'b1));
            else
                send_beat(pack_beat(i2cram_pkg::ACT_TICK, 7'h55, 8'haa, 8'h55, 1'b1));
        end
        send_beat(pack_beat(i2cram_pkg::ACT_TICK, 7'h2a, 8'h55, 8'haa, 1'b0));
        drain();

        for (k = 0; k < NUM_STAGES; k++)
        begin
            write_limit(limit_plan[k]);
            stage_base = beats_sent;
            while (beats_sent - stage_base < STAGE_BEATS)
                run_transfer();
            drain();
        end

        repeat (4) @(posedge clk);
        if (error_cnt == 0 && pending_cnt == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule

// ===== i2c_register_access_master.f =====
sv/i2cram_pkg.sv
sv/i2c_register_access_master.sv
dv/i2cram_checker.sv
dv/testbench.sv
